// File: src/hia_pkg.sv
// ----------------------------------------------------------------------------
// hia_pkg: shared types and codes for the handle index allocator
// Word formats for both channels, opcode and status codes, and the
// operation token that travels down the ring cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package hia_pkg;

  // field widths fixed by the word formats
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned OPC_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 7;

  localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = 7'd64;

  // request opcodes
  typedef logic [OPC_W-1:0] opcode_t;
  localparam opcode_t OPC_ALLOC   = 2'd0;
  localparam opcode_t OPC_RELEASE = 2'd1;
  localparam opcode_t OPC_CLEAR   = 2'd2;

  // response status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EXHAUSTED = 2'd1;
  localparam status_t ST_DROPPED   = 2'd2;
  localparam status_t ST_RANGE     = 2'd3;

  // input word
  typedef struct packed {
    opcode_t            opcode;
    logic [IDX_W-1:0]   release_index;
  } hia_req_t;

  // output word
  typedef struct packed {
    logic [IDX_W-1:0]   granted_index;
    status_t            status;
  } hia_rsp_t;

  // what a token does when it reaches the cell at its ring position
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_READ,
    KIND_WRITE
  } ring_kind_t;

  // operation token handed from cell to cell
  typedef struct packed {
    logic               valid;
    ring_kind_t         kind;
    logic [IDX_W-1:0]   data;
    status_t            status;
  } ring_op_t;

endpackage

`default_nettype wire

// File: src/handle_index_allocator_core.sv
// ----------------------------------------------------------------------------
// handle_index_allocator_core: slot index allocator with free queue and bump
// Hands out, takes back and clears slot indices from a pool of handles.
//
// Input channel in_valid/in_stall/in_data carries one request word (opcode,
// release index); output channel out_valid/out_stall/out_data returns one
// response word (granted index, status) per request, in request order.
// cfg_we/cfg_wdata write the pool size; write it only while idle.
//
// Requests are decided combinationally by the control unit as they are
// accepted, then a token walks the chain of free queue cells, one cell per
// cycle while the output is not stalled, to read or write its queue entry.
// The response word comes from the register of the last of the DEPTH cells,
// DEPTH = min(MAX_SLOTS, 127); throughput is one word per cycle while the
// output is not stalled. A stalled output freezes the whole chain and the
// response holds; the input then stalls in the same cycle. Reset sets the
// pool size to 64 and empties the queue and bump counter; no clearing pass
// is needed, so a request may be sent in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_index_allocator_core #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [hia_pkg::SLOT_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire hia_pkg::hia_req_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output hia_pkg::hia_rsp_t               out_data
);
  import hia_pkg::*;

  // positions never exceed what a 7-bit pool size can reach
  localparam int unsigned DEPTH = (MAX_SLOTS < 127) ? MAX_SLOTS : 127;
  localparam int unsigned POS_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ring_op_t         op_chain  [DEPTH+1];
  logic [POS_W-1:0] pos_chain [DEPTH+1];
  logic             en;
  logic             accept;
  ring_op_t         last_op;

  // chain moves unless the last word is held by the receiver
  assign last_op  = op_chain[DEPTH];
  assign en       = !(last_op.valid && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  hia_ctrl #(
    .DEPTH (DEPTH),
    .POS_W (POS_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .req       (in_data),
    .op        (op_chain[0]),
    .op_pos    (pos_chain[0])
  );

  // free queue cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    hia_cell #(
      .POS_W   (POS_W),
      .CELL_ID (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .op_in   (op_chain[k]),
      .pos_in  (pos_chain[k]),
      .op_out  (op_chain[k+1]),
      .pos_out (pos_chain[k+1])
    );
  end

  // response word from the last cell
  assign out_valid              = last_op.valid;
  assign out_data.granted_index = (last_op.kind == KIND_WRITE) ? '0 : last_op.data;
  assign out_data.status        = last_op.status;

endmodule

`default_nettype wire

// File: src/hia_ctrl.sv
// ----------------------------------------------------------------------------
// hia_ctrl: pointer and counter control
// Holds the pool size register, queue head/tail/fill and the bump counter,
// decides each request combinationally and issues a ring token to the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module hia_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned POS_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [hia_pkg::SLOT_W-1:0] cfg_wdata,
  input  wire logic                     accept,
  input  wire hia_pkg::hia_req_t        req,
  output hia_pkg::ring_op_t             op,
  output logic [POS_W-1:0]              op_pos
);
  import hia_pkg::*;

  logic [SLOT_W-1:0] slot_count;
  logic [POS_W-1:0]  head, head_next;
  logic [POS_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [CNT_W-1:0]  bump_top, bump_top_next;
  logic [CNT_W-1:0]  pool_n;

  // step a queue position, wrapping at the pool size
  function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] pos,
                                                input logic [CNT_W-1:0] n);
    logic [7:0] nxt;
    nxt = 8'(pos) + 8'd1;
    if (nxt >= 8'(n)) begin
      wrap_inc = '0;
    end else begin
      wrap_inc = POS_W'(nxt);
    end
  endfunction

  // effective pool size saturates at the ring depth
  always_comb begin
    if (slot_count > SLOT_W'(DEPTH)) begin
      pool_n = CNT_W'(DEPTH);
    end else begin
      pool_n = CNT_W'(slot_count);
    end
  end

  // request decode and next counter values
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    fill_next     = fill;
    bump_top_next = bump_top;
    op            = '{valid: accept, kind: KIND_NONE, data: '0, status: ST_OK};
    op_pos        = head;
    case (req.opcode)
      OPC_ALLOC: begin
        if (fill != '0 && pool_n != '0) begin
          op.kind   = KIND_READ;
          op_pos    = head;
          head_next = wrap_inc(head, pool_n);
          fill_next = fill - CNT_W'(1);
        end else if (bump_top < pool_n) begin
          op.data       = IDX_W'(bump_top);
          bump_top_next = bump_top + CNT_W'(1);
        end else begin
          op.status = ST_EXHAUSTED;
        end
      end
      OPC_RELEASE: begin
        if (SLOT_W'(req.release_index) >= SLOT_W'(pool_n)) begin
          op.status = ST_RANGE;
        end else if (fill >= pool_n) begin
          op.status = ST_DROPPED;
        end else begin
          op.kind   = KIND_WRITE;
          op.data   = req.release_index;
          op_pos    = tail;
          tail_next = wrap_inc(tail, pool_n);
          fill_next = fill + CNT_W'(1);
        end
      end
      OPC_CLEAR: begin
        head_next     = '0;
        tail_next     = '0;
        fill_next     = '0;
        bump_top_next = '0;
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RESET;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      bump_top   <= '0;
    end else begin
      if (cfg_we) begin
        slot_count <= cfg_wdata;
      end
      if (accept) begin
        head     <= head_next;
        tail     <= tail_next;
        fill     <= fill_next;
        bump_top <= bump_top_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/hia_cell.sv
// ----------------------------------------------------------------------------
// hia_cell: one free queue entry in the cell chain
// Stores one queued index; a passing token that targets this position
// writes the entry or picks up its value, then moves to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module hia_cell #(
  parameter int unsigned POS_W   = 6,
  parameter int unsigned CELL_ID = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire hia_pkg::ring_op_t  op_in,
  input  wire logic [POS_W-1:0]   pos_in,
  output hia_pkg::ring_op_t       op_out,
  output logic [POS_W-1:0]        pos_out
);
  import hia_pkg::*;

  logic [IDX_W-1:0] entry;
  logic             hit;
  ring_op_t         op_next;

  assign hit = op_in.valid && (pos_in == POS_W'(CELL_ID));

  // read picks up the stored index on the way past
  always_comb begin
    op_next = op_in;
    if (hit && op_in.kind == KIND_READ) begin
      op_next.data = entry;
    end
  end

  // entry storage, written by a release token
  always_ff @(posedge clk) begin
    if (en && hit && op_in.kind == KIND_WRITE) begin
      entry <= op_in.data;
    end
  end

  // hand the token to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      op_out.valid <= 1'b0;
    end else if (en) begin
      op_out.valid <= op_next.valid;
    end
    if (en) begin
      op_out.kind   <= op_next.kind;
      op_out.data   <= op_next.data;
      op_out.status <= op_next.status;
      pos_out       <= pos_in;
    end
  end

endmodule

`default_nettype wire

// File: bench/handle_index_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// handle_index_allocator_core_tb: self-checking bench for the slot allocator
// Drives allocate, release, clear and unused-opcode words through the
// request channel, keeps a cycle-free model of the free queue and bump
// counter, and checks every response word in order. Runs through several
// pool sizes, including zero and saturated ones, with and without gaps on
// the request side and stalls on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_index_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hia_pkg::*;

  localparam int unsigned MAX_SLOTS = 64;
  localparam opcode_t OPC_UNUSED = 2'd3;
  localparam int NUM_PHASES = 16;
  localparam int WORDS_PER_PHASE = 106;
  localparam int END_PAUSE = 70;      // chain depth, with margin
  localparam int QUIET_LIMIT = 4000;  // cycles with no word moving on either side
  localparam logic [SLOT_W-1:0] PHASE_SLOTS [14] = '{
    7'd64, 7'd1, 7'd127, 7'd2, 7'd0, 7'd65, 7'd3,
    7'd64, 7'd8, 7'd1, 7'd127, 7'd16, 7'd63, 7'd5
  };

  // tracks the free queue and bump counter, holds the responses still owed
  class grant_scoreboard;
    logic [IDX_W-1:0] ring [MAX_SLOTS];
    bit ring_written [MAX_SLOTS];
    int unsigned head, tail, fill, bump;
    int unsigned slot_count;
    hia_rsp_t owed_responses [$];
    int unsigned errors;

    function new();
      slot_count = SLOT_COUNT_RESET;
    endfunction

    function void set_slot_count(logic [SLOT_W-1:0] value);
      slot_count = value;
    endfunction

    function int unsigned pool_size();
      return (slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count;
    endfunction

    function int unsigned next_pos(int unsigned pos, int unsigned n);
      return (pos + 1 >= n || pos + 1 >= MAX_SLOTS) ? 0 : pos + 1;
    endfunction

    // an allocate now would pop a queue entry that was never written
    function bit alloc_reads_unwritten();
      return fill > 0 && pool_size() > 0 && !ring_written[head];
    endfunction

    function void note_request(hia_req_t req);
      int unsigned n;
      hia_rsp_t rsp;
      n = pool_size();
      rsp = '0;
      rsp.status = ST_OK;
      case (req.opcode)
        OPC_ALLOC: begin
          if (fill > 0 && n > 0) begin
            rsp.granted_index = ring[head];
            head = next_pos(head, n);
            fill--;
          end else if (bump < n) begin
            rsp.granted_index = IDX_W'(bump);
            bump++;
          end else begin
            rsp.status = ST_EXHAUSTED;
          end
        end
        OPC_RELEASE: begin
          if (req.release_index >= n) begin
            rsp.status = ST_RANGE;
          end else if (fill >= n) begin
            rsp.status = ST_DROPPED;
          end else begin
            ring[tail] = req.release_index;
            ring_written[tail] = 1'b1;
            tail = next_pos(tail, n);
            fill++;
          end
        end
        OPC_CLEAR: begin
          head = 0;
          tail = 0;
          fill = 0;
          bump = 0;
        end
        default: ;
      endcase
      owed_responses.push_back(rsp);
    endfunction

    function void check_response(hia_rsp_t got);
      hia_rsp_t want;
      if (owed_responses.size() == 0) begin
        $display("%0t: unexpected response word: granted_index %0d status %0d",
                 $time, got.granted_index, got.status);
        errors++;
        return;
      end
      want = owed_responses.pop_front();
      if (got.granted_index !== want.granted_index) begin
        $display("%0t: granted_index mismatch: expected %0d actual %0d",
                 $time, want.granted_index, got.granted_index);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [SLOT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  hia_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hia_rsp_t out_data;

  grant_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  handle_index_allocator_core #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  // response check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_response(out_data);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request word, with random gaps ahead of it
  task automatic send_word(opcode_t op, logic [IDX_W-1:0] idx);
    hia_req_t w;
    // never pop a queue entry that was not written since reset
    if (op == OPC_ALLOC && sb.alloc_reads_unwritten()) op = OPC_CLEAR;
    w.opcode = op;
    w.release_index = idx;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(w);
  endtask

  // stop sending and wait for every owed response
  task automatic drain_responses();
    in_valid <= 1'b0;
    while (sb.owed_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [SLOT_W-1:0] value);
    drain_responses();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_slot_count(value);
  endtask

  initial begin
    int unsigned n;
    int unsigned r;
    int chunk_left;
    bit alloc_heavy;
    logic [SLOT_W-1:0] slots;
    opcode_t op;
    logic [IDX_W-1:0] idx;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: bump, queue reuse, double release, unused opcode, clear
    send_word(OPC_ALLOC, 6'd0);
    send_word(OPC_ALLOC, 6'd63);
    send_word(OPC_RELEASE, 6'd63);
    send_word(OPC_RELEASE, 6'd0);
    send_word(OPC_RELEASE, 6'd0);
    send_word(OPC_UNUSED, 6'd63);
    send_word(OPC_ALLOC, 6'd0);
    send_word(OPC_ALLOC, 6'd0);
    send_word(OPC_CLEAR, 6'd63);
    send_word(OPC_ALLOC, 6'd0);
    // single slot: exhaustion, range, full queue drop, wrap
    write_slot_count(7'd1);
    send_word(OPC_ALLOC, 6'd0);
    send_word(OPC_RELEASE, 6'd1);
    send_word(OPC_RELEASE, 6'd0);
    send_word(OPC_RELEASE, 6'd0);
    send_word(OPC_ALLOC, 6'd0);
    send_word(OPC_CLEAR, 6'd0);
    send_word(OPC_ALLOC, 6'd0);
    // empty pool
    write_slot_count(7'd0);
    send_word(OPC_ALLOC, 6'd0);
    send_word(OPC_RELEASE, 6'd0);
    send_word(OPC_RELEASE, 6'd63);
    // oversized pool saturates
    write_slot_count(7'd127);
    send_word(OPC_RELEASE, 6'd63);
    send_word(OPC_ALLOC, 6'd0);
    send_word(OPC_UNUSED, 6'd0);
    send_word(OPC_ALLOC, 6'd0);

    // random phases, pool size changed with entries possibly still queued
    chunk_left = 0;
    alloc_heavy = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      slots = (p < 14) ? PHASE_SLOTS[p] : SLOT_W'($urandom_range(127, 1));
      write_slot_count(slots);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // alternate alloc-heavy and release-heavy runs so the queue swings
        if (chunk_left == 0) begin
          alloc_heavy = ~alloc_heavy;
          chunk_left = $urandom_range(80, 4);
        end
        chunk_left--;
        n = sb.pool_size();
        r = $urandom_range(99);
        if (r < (alloc_heavy ? 70 : 25)) op = OPC_ALLOC;
        else if (r < 98) op = OPC_RELEASE;
        else if (r < 99) op = OPC_CLEAR;
        else op = OPC_UNUSED;
        if (n > 0 && $urandom_range(3) != 0) idx = IDX_W'($urandom_range(n - 1, 0));
        else idx = IDX_W'($urandom_range(63, 0));
        send_word(op, idx);
      end
    end

    drain_responses();
    repeat (END_PAUSE) @(posedge clk);
    if (sb.errors == 0 && sb.owed_responses.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/hia_pkg.sv
src/hia_ctrl.sv
src/hia_cell.sv
src/handle_index_allocator_core.sv
bench/handle_index_allocator_core_tb.sv
